FILE: rtl/core/deq_pkg.sv
// Package for the double-ended queue core: sizes, field widths and action and status codes.
package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_BACK   = 2'd2,
        ACT_POP_FRONT  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

endpackage

FILE: rtl/core/double_ended_queue_core.sv
// Top level of the double-ended queue core: pointer control, ring RAM and result stages.
//
// This core is a double-ended queue of DEPTH words held in a ring RAM with front and back
// pointers and an entry count. Each input item carries an action in s_tuser (push back,
// push front, pop back, pop front) and a word in s_tdata, and yields exactly one result
// item: the popped word (zero for pushes and failed pops), the count after the action,
// empty and full flags, and a status code in m_tuser. A pop on an empty queue reports
// underflow and changes nothing; a push on a full queue reports overflow and the word is
// dropped. Pointers and count are updated in the cycle an item is accepted, and the RAM
// is written or read in that same cycle, so the core takes one item per clock as long as
// the receiver keeps taking results. A result passes through the registered RAM read and
// then the output register. The RAM needs no clearing after reset, since a pop only reads
// slots that an earlier push wrote.
module double_ended_queue_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [deq_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] push_value
    input  logic [deq_pkg::ACTION_W-1:0]       s_tuser,   // [1:0] action
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [deq_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] pop_value,
                                                          // [36:32] entry_count,
                                                          // [37] is_empty_flag,
                                                          // [38] is_full_flag,
                                                          // [39] zero padding
    output logic [deq_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);

    import deq_pkg::*;

    // Ring pointers step modulo DEPTH, which need not be a power of two.
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        ptr_inc = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        ptr_dec = (p == '0) ? ADDR_W'(DEPTH - 1) : p - ADDR_W'(1);
    endfunction

    // Queue state.
    logic [ADDR_W-1:0]     front_reg, front_next;
    logic [ADDR_W-1:0]     back_reg, back_next;
    logic [CNT_W-1:0]      occupancy_reg, occupancy_next;

    // Stage one: the result waits here while the RAM read completes.
    logic                  p_valid_reg;
    logic                  p_pop_reg;
    logic [CNT_W-1:0]      p_count_reg;
    status_t               p_status_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [VALUE_W-1:0]    m_value_reg;
    logic [CNT_W-1:0]      m_count_reg;
    logic                  m_empty_reg;
    logic                  m_full_reg;
    status_t               m_status_reg;

    // RAM ports.
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  in_accept;
    logic                  advance;
    logic                  ring_full;
    logic                  ring_empty;
    action_t               action;
    status_t               status_now;
    logic                  pop_ok;
    logic [63:0]           in_wide;
    logic [63:0]           rd_wide;
    logic [31:0]           count_wide;

    assign action     = action_t'(s_tuser);
    assign ring_full  = (occupancy_reg == CNT_W'(DEPTH));
    assign ring_empty = (occupancy_reg == '0);

    // Stage one moves into the output register when that register is free or being taken.
    assign advance   = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !p_valid_reg || !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    // Only the low DATA_WIDTH bits of a pushed word are stored.
    assign in_wide   = 64'(s_tdata);
    assign ram_wdata = in_wide[DATA_WIDTH-1:0];

    // Decide the action, the RAM access and the new pointers for an accepted item.
    always_comb
    begin
        front_next     = front_reg;
        back_next      = back_reg;
        occupancy_next = occupancy_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = back_reg;
        status_now     = ST_OK;
        pop_ok         = 1'b0;
        unique case (action)
            ACT_PUSH_BACK:
            begin
                ram_addr = back_reg;
                if (ring_full)
                begin
                    status_now = ST_OVERFLOW;
                end
                else
                begin
                    ram_we         = in_accept;
                    back_next      = ptr_inc(back_reg);
                    occupancy_next = occupancy_reg + CNT_W'(1);
                end
            end
            ACT_PUSH_FRONT:
            begin
                ram_addr = ptr_dec(front_reg);
                if (ring_full)
                begin
                    status_now = ST_OVERFLOW;
                end
                else
                begin
                    ram_we         = in_accept;
                    front_next     = ptr_dec(front_reg);
                    occupancy_next = occupancy_reg + CNT_W'(1);
                end
            end
            ACT_POP_BACK:
            begin
                ram_addr = ptr_dec(back_reg);
                if (ring_empty)
                begin
                    status_now = ST_UNDERFLOW;
                end
                else
                begin
                    ram_re         = in_accept;
                    pop_ok         = 1'b1;
                    back_next      = ptr_dec(back_reg);
                    occupancy_next = occupancy_reg - CNT_W'(1);
                end
            end
            ACT_POP_FRONT:
            begin
                ram_addr = front_reg;
                if (ring_empty)
                begin
                    status_now = ST_UNDERFLOW;
                end
                else
                begin
                    ram_re         = in_accept;
                    pop_ok         = 1'b1;
                    front_next     = ptr_inc(front_reg);
                    occupancy_next = occupancy_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_now = ST_OK;
            end
        endcase
    end

    // Each item makes at most one access, so the ring needs a single address.
    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Queue state and valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= '0;
            occupancy_reg <= '0;
            p_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                front_reg     <= front_next;
                back_reg      <= back_next;
                occupancy_reg <= occupancy_next;
            end
            if (in_accept)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                p_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The RAM read data is valid while stage one holds its item, since no new read is
    // issued until that item moves on.
    assign rd_wide = 64'(ram_rdata);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_pop_reg    <= pop_ok;
            p_count_reg  <= occupancy_next;
            p_status_reg <= status_now;
        end
        if (advance)
        begin
            m_value_reg  <= p_pop_reg ? rd_wide[VALUE_W-1:0] : '0;
            m_count_reg  <= p_count_reg;
            m_empty_reg  <= (p_count_reg == '0);
            m_full_reg   <= (p_count_reg == CNT_W'(DEPTH));
            m_status_reg <= p_status_reg;
        end
    end

    assign count_wide = 32'(m_count_reg);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {1'b0, m_full_reg, m_empty_reg, count_wide[COUNT_W-1:0], m_value_reg};
    assign m_tuser    = m_status_reg;

    // The count never exceeds the ring size.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= CNT_W'(DEPTH))
        else $error("occupancy exceeds depth");

    // An empty or a full ring has both pointers on the same slot.
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_empty || ring_full) |-> (front_reg == back_reg))
        else $error("pointers disagree with occupancy");

    // A successful pop lowers the count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && ram_re) |=> (occupancy_reg == $past(occupancy_reg) - CNT_W'(1)))
        else $error("pop did not decrement occupancy");

    // While stage one is stalled no read may disturb its RAM data.
    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && !advance) |-> !ram_re)
        else $error("RAM read issued while stage one is stalled");

    // An overflow is only reported with the full flag set.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_status_reg == ST_OVERFLOW)) |-> m_full_reg)
        else $error("overflow without full flag");

endmodule

FILE: rtl/core/deq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sim/deq_result_checker.sv
// Result checker for the double-ended queue core: predicts every result item and compares it.
`timescale 1ns / 1ps

module deq_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [deq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [deq_pkg::ACTION_W-1:0]    s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [deq_pkg::STATUS_W-1:0]    m_tuser,
    output int                              mismatches,
    output int                              pending,
    output int                              n_items,
    output int                              n_pushes,
    output int                              n_pops,
    output int                              n_underflows,
    output int                              n_overflows,
    output int                              n_full_hits,
    output int                              n_empty_hits
);

    import deq_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               full;
        status_t            status;
    } deq_reply_t;

    // Shadow copy of the queue contents and pointers.
    logic [DATA_WIDTH-1:0] slots [DEPTH];
    logic [ADDR_W-1:0]     front_slot;
    logic [ADDR_W-1:0]     back_slot;
    logic [CNT_W-1:0]      stored;

    deq_reply_t predicted_replies [$];

    function automatic logic [ADDR_W-1:0] slot_after(input logic [ADDR_W-1:0] i);
        return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_before(input logic [ADDR_W-1:0] i);
        return (i == '0) ? ADDR_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // Applies one action to the shadow queue and returns the result it must produce.
    function automatic deq_reply_t apply_action(input action_t act,
                                                input logic [DATA_WIDTH-1:0] word);
        deq_reply_t r;
        r.value  = '0;
        r.status = ST_OK;
        if (act == ACT_PUSH_BACK || act == ACT_PUSH_FRONT)
        begin
            if (stored == CNT_W'(DEPTH))
            begin
                r.status = ST_OVERFLOW;
                n_overflows++;
            end
            else
            begin
                if (act == ACT_PUSH_BACK)
                begin
                    slots[back_slot] = word;
                    back_slot = slot_after(back_slot);
                end
                else
                begin
                    front_slot = slot_before(front_slot);
                    slots[front_slot] = word;
                end
                stored = stored + 1'b1;
                n_pushes++;
                if (stored == CNT_W'(DEPTH))
                    n_full_hits++;
            end
        end
        else
        begin
            if (stored == '0)
            begin
                r.status = ST_UNDERFLOW;
                n_underflows++;
            end
            else
            begin
                if (act == ACT_POP_BACK)
                begin
                    back_slot = slot_before(back_slot);
                    r.value = VALUE_W'(slots[back_slot]);
                end
                else
                begin
                    r.value = VALUE_W'(slots[front_slot]);
                    front_slot = slot_after(front_slot);
                end
                stored = stored - 1'b1;
                n_pops++;
                if (stored == '0)
                    n_empty_hits++;
            end
        end
        r.count = COUNT_W'(stored);
        r.empty = (stored == '0);
        r.full  = (stored == CNT_W'(DEPTH));
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] deq mismatch in %s: got 0x%0h, expected 0x%0h",
                 $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deq_reply_t want;
        if (!rst_n)
        begin
            front_slot = '0;
            back_slot  = '0;
            stored     = '0;
            predicted_replies.delete();
            pending    = 0;
        end
        else
        begin
            // Results first: a result leaving at this edge belongs to an earlier item.
            if (m_tvalid && m_tready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(m_tdata), '0);
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report_mismatch("pop_value", 64'(m_tdata[31:0]), 64'(want.value));
                    if (m_tdata[36:32] !== want.count)
                        report_mismatch("entry_count", 64'(m_tdata[36:32]),
                                        64'(want.count));
                    if (m_tdata[37] !== want.empty)
                        report_mismatch("is_empty_flag", 64'(m_tdata[37]), 64'(want.empty));
                    if (m_tdata[38] !== want.full)
                        report_mismatch("is_full_flag", 64'(m_tdata[38]), 64'(want.full));
                    if (m_tdata[39] !== 1'b0)
                        report_mismatch("tdata padding", 64'(m_tdata[39]), '0);
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(m_tuser), 64'(want.status));
                end
            end
            if (s_tvalid && s_tready)
            begin
                n_items++;
                predicted_replies.push_back(apply_action(action_t'(s_tuser),
                                                         s_tdata[DATA_WIDTH-1:0]));
            end
            pending = predicted_replies.size();
        end
    end

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        n_items      = 0;
        n_pushes     = 0;
        n_pops       = 0;
        n_underflows = 0;
        n_overflows  = 0;
        n_full_hits  = 0;
        n_empty_hits = 0;
    end

endmodule

FILE: sim/tb_double_ended_queue_core.sv
// Testbench top for the double-ended queue core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_double_ended_queue_core;

    import deq_pkg::*;

    // A run is stuck if nothing moves on either channel for this many cycles.
    localparam int STALL_LIMIT = 4000;
    // Length of the deliberate receiver hold-off that fills the core.
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [ACTION_W-1:0]    s_tuser = ACT_PUSH_BACK;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    int mismatches, pending, n_items, n_pushes, n_pops;
    int n_underflows, n_overflows, n_full_hits, n_empty_hits;

    // Flow-control knobs shared between the stimulus and the receiver.
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;
    bit hold_request = 1'b0;
    int holds_done = 0;
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    double_ended_queue_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    deq_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .pending      (pending),
        .n_items      (n_items),
        .n_pushes     (n_pushes),
        .n_pops       (n_pops),
        .n_underflows (n_underflows),
        .n_overflows  (n_overflows),
        .n_full_hits  (n_full_hits),
        .n_empty_hits (n_empty_hits)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int idle_len(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // Data words lean toward all zeros and all ones so both extremes show up often.
    function automatic logic [31:0] random_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // Offers one item, starting at a falling edge, and returns at the falling edge after
    // it was taken. The valid stays high when the next item follows without a gap.
    task automatic put_item(input action_t act, input logic [31:0] word);
        int gap;
        gap = idle_len(src_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Random actions in short runs, each run leaning toward filling, draining or neither,
    // so the queue keeps sweeping between empty and full and wraps its pointers.
    task automatic run_mix(input int count);
        int push_pct;
        push_pct = 50;
        for (int k = 0; k < count; k++) begin
            if (k % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < push_pct)
                put_item($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                         random_word());
            else
                put_item($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK,
                         random_word());
        end
    endtask

    // Drops the valid and waits until every predicted result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls of the same shape as the sender gaps, plus the long
    // hold-off on request, counted here so the sender keeps pushing meanwhile.
    initial
    begin
        int len;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else begin
                len = idle_len(sink_steady);
                if (len == 0)
                    m_tready <= 1'b1;
                else begin
                    m_tready <= 1'b0;
                    repeat (len - 1) @(negedge clk);
                end
            end
        end
    end

    // Watchdog: any handshake on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("Run stalled for %0d cycles with %0d results outstanding.",
                     idle_cycles, pending);
            $display("tb_double_ended_queue_core: FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Both pops on an empty queue must underflow.
        put_item(ACT_POP_BACK, 32'hDEAD_BEEF);
        put_item(ACT_POP_FRONT, 32'hFFFF_FFFF);
        // A push at the front right after reset wraps the front pointer downward.
        put_item(ACT_PUSH_BACK, 32'h0000_0000);
        put_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        put_item(ACT_POP_BACK, 32'h0000_0000);
        put_item(ACT_POP_FRONT, 32'h0000_0000);
        // Fill to the last slot from both ends, then push once more at each end.
        for (int k = 0; k < DEPTH; k++) begin
            case (k % 4)
                0: put_item(ACT_PUSH_BACK, 32'hAAAA_AAAA ^ k);
                1: put_item(ACT_PUSH_FRONT, 32'h5555_5555 ^ k);
                2: put_item(ACT_PUSH_BACK, 32'h8000_0001 ^ k);
                default: put_item(ACT_PUSH_FRONT, 32'h7FFF_FFFE ^ k);
            endcase
        end
        put_item(ACT_PUSH_BACK, 32'h1234_5678);
        put_item(ACT_PUSH_FRONT, 32'h8765_4321);
        put_item(ACT_POP_FRONT, 32'h0000_0000);
        put_item(ACT_POP_BACK, 32'hFFFF_FFFF);

        run_mix(520);

        // The sender pauses here until the core has delivered everything.
        drain_results();
        @(negedge clk);

        // Long receiver hold-off while the sender keeps offering items back to back,
        // so the result path backs up and the core must stall its input.
        hold_request = 1'b1;
        src_steady   = 1'b1;
        for (int k = 0; k < 48; k++)
            put_item($urandom_range(0, 3) == 0 ? ACT_POP_BACK : ACT_PUSH_BACK,
                     random_word());
        src_steady = 1'b0;

        run_mix(500);
        drain_results();
        @(negedge clk);
        run_mix(456);

        drain_results();
        repeat (8) @(posedge clk);

        $display("Run covered %0d items: %0d pushes, %0d pops, %0d underflows, %0d overflows.",
                 n_items, n_pushes, n_pops, n_underflows, n_overflows);
        $display("Queue went full %0d times and empty %0d times; %0d long receiver hold-offs.",
                 n_full_hits, n_empty_hits, holds_done);
        if (mismatches == 0)
            $display("tb_double_ended_queue_core: PASS");
        else
            $display("tb_double_ended_queue_core: FAIL");
        $finish;
    end

endmodule
